// ===== src/cpl_pkg.sv =====
package cpl_pkg;

    // Packet geometry
    localparam int DATA_BYTES  = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int HDR_LEN     = DATA_BYTES + 2;
    localparam int PKT_LEN     = DATA_BYTES + 3;
    localparam int HDR_BITS    = HDR_LEN * 8;
    // data bytes carried by the 32-bit payload fields
    localparam int PAY_BYTES   = (DATA_BYTES < 4) ? DATA_BYTES : 4;
    // result records buffered ahead of the serializer
    localparam int TXQ_DEPTH   = 4;

    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] CRC_INIT  = 8'h00;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    // Request kinds
    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_SEND = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Register indexes and reset values
    localparam logic [1:0] CFG_CMD_TYPE  = 2'd0;
    localparam logic [1:0] CFG_ACK_TYPE  = 2'd1;
    localparam logic [1:0] CFG_RETX_TYPE = 2'd2;
    localparam logic [7:0] CMD_TYPE_RST  = 8'd1;
    localparam logic [7:0] ACK_TYPE_RST  = 8'd2;
    localparam logic [7:0] RETX_TYPE_RST = 8'd3;

    typedef logic [HDR_LEN-1:0][7:0]    t_hdr;
    typedef logic [PKT_LEN-1:0][7:0]    t_pkt;
    typedef logic [DATA_BYTES:0][7:0]   t_entry;   // byte 0 command, then data
    typedef logic [HDR_BITS-1:0][7:0]   t_crc_tbl;

    // Receiver status at the CRC byte
    typedef struct packed {
        logic done;
        logic crc_ok;
        t_hdr hdr;
    } t_rx_done;

    // One buffered result: a whole packet or one read response
    typedef struct packed {
        logic is_read;
        logic rd_valid;
        logic ack;
        logic ovf;
        t_pkt bytes;
    } t_rec;

    // CRC-8 over one byte, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Contribution of each header bit to the CRC (the code is linear, init 0)
    function automatic t_crc_tbl crc8_tbl_build();
        t_crc_tbl   tbl;
        t_hdr       h;
        logic [7:0] c;
        tbl = '0;
        for (int i = 0; i < HDR_LEN; i++) begin
            for (int k = 0; k < 8; k++) begin
                h       = '0;
                h[i][k] = 1'b1;
                c       = CRC_INIT;
                for (int j = 0; j < HDR_LEN; j++) begin
                    c = crc8_byte(c, h[j]);
                end
                tbl[i*8+k] = c;
            end
        end
        return tbl;
    endfunction

    localparam t_crc_tbl CRC_TBL = crc8_tbl_build();

    // Header CRC as an xor of per-bit terms
    function automatic logic [7:0] crc8_hdr(input t_hdr h);
        logic [7:0] c;
        c = CRC_INIT;
        for (int i = 0; i < HDR_LEN; i++) begin
            for (int k = 0; k < 8; k++) begin
                if (h[i][k]) begin
                    c = c ^ CRC_TBL[i*8+k];
                end
            end
        end
        return c;
    endfunction

    // Append the CRC byte
    function automatic t_pkt make_pkt(input t_hdr h);
        t_pkt p;
        for (int i = 0; i < HDR_LEN; i++) begin
            p[i] = h[i];
        end
        p[HDR_LEN] = crc8_hdr(h);
        return p;
    endfunction

    // Ack and retransmit request headers: type, then all 0xFF
    function automatic t_hdr ctrl_hdr(input logic [7:0] pkt_type);
        t_hdr h;
        for (int i = 0; i < HDR_LEN; i++) begin
            h[i] = FILL_BYTE;
        end
        h[0] = pkt_type;
        return h;
    endfunction

endpackage

// ===== src/cpl_rx.sv =====
module cpl_rx (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_valid,
    input  logic [7:0]         i_byte,
    output cpl_pkg::t_rx_done  o_done
);

    localparam logic [1:0] RX_TYPE = 2'd0;
    localparam logic [1:0] RX_CMD  = 2'd1;
    localparam logic [1:0] RX_DATA = 2'd2;
    localparam logic [1:0] RX_CRC  = 2'd3;
    localparam int CNT_W = $clog2(cpl_pkg::DATA_BYTES + 1);

    logic [1:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_crc, n_crc;
    cpl_pkg::t_hdr    r_hdr, n_hdr;

    // Completion is seen on the CRC byte itself
    assign o_done.done   = i_byte_valid && (r_phase == RX_CRC);
    assign o_done.crc_ok = (i_byte == r_crc);
    assign o_done.hdr    = r_hdr;

    // Byte assembly and running CRC
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        n_hdr   = r_hdr;
        if (i_byte_valid) begin
            unique case (r_phase)
                RX_TYPE: begin
                    n_hdr[0] = i_byte;
                    n_crc    = cpl_pkg::crc8_byte(cpl_pkg::CRC_INIT, i_byte);
                    n_phase  = RX_CMD;
                end
                RX_CMD: begin
                    n_hdr[1] = i_byte;
                    n_crc    = cpl_pkg::crc8_byte(r_crc, i_byte);
                    n_cnt    = '0;
                    n_phase  = RX_DATA;
                end
                RX_DATA: begin
                    for (int i = 0; i < cpl_pkg::DATA_BYTES; i++) begin
                        if (r_cnt == CNT_W'(i)) begin
                            n_hdr[2+i] = i_byte;
                        end
                    end
                    n_crc = cpl_pkg::crc8_byte(r_crc, i_byte);
                    n_cnt = r_cnt + 1'b1;
                    if (n_cnt == CNT_W'(cpl_pkg::DATA_BYTES)) begin
                        n_phase = RX_CRC;
                    end
                end
                RX_CRC: begin
                    n_phase = RX_TYPE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= RX_TYPE;
            r_cnt   <= '0;
            r_crc   <= cpl_pkg::CRC_INIT;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
        end
    end

    // header bytes are always written before they are used
    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

endmodule

// ===== src/cpl_cmdq.sv =====
module cpl_cmdq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cpl_pkg::t_entry  i_push_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output cpl_pkg::t_entry  o_head
);

    localparam int IDX_W = $clog2(cpl_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cpl_pkg::QUEUE_DEPTH + 1);

    logic [IDX_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    cpl_pkg::t_entry  r_mem [cpl_pkg::QUEUE_DEPTH];

    assign o_full  = (r_cnt == CNT_W'(cpl_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // Pointers wrap at the queue depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == IDX_W'(cpl_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == IDX_W'(cpl_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_entry;
        end
    end

endmodule

// ===== src/cpl_txq.sv =====
module cpl_txq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cpl_pkg::t_rec   i_rec,
    output logic            o_full,
    input  logic            i_stall,
    output logic            o_valid,
    output logic            o_out_kind,
    output logic [7:0]      o_tx_byte,
    output logic            o_tx_last,
    output logic            o_read_valid,
    output logic [7:0]      o_read_command,
    output logic [31:0]     o_read_payload,
    output logic            o_ack_pending,
    output logic            o_overflow_seen
);

    localparam int IDX_W  = $clog2(cpl_pkg::TXQ_DEPTH);
    localparam int CNT_W  = $clog2(cpl_pkg::TXQ_DEPTH + 1);
    localparam int BYTE_W = $clog2(cpl_pkg::PKT_LEN);

    logic [IDX_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic [BYTE_W-1:0] r_byte;
    cpl_pkg::t_rec     r_mem [cpl_pkg::TXQ_DEPTH];
    cpl_pkg::t_rec     w_head;
    logic              w_last_byte;
    logic              w_out_acc;
    logic              w_pop;

    assign w_head      = r_mem[r_rd];
    assign o_valid     = (r_cnt != '0);
    assign o_full      = (r_cnt == CNT_W'(cpl_pkg::TXQ_DEPTH));
    assign w_last_byte = (r_byte == BYTE_W'(cpl_pkg::PKT_LEN - 1));
    assign w_out_acc   = o_valid && !i_stall;
    assign w_pop       = w_out_acc && (w_head.is_read || w_last_byte);

    // Result fields from the head record
    always_comb begin
        o_out_kind      = 1'b0;
        o_tx_byte       = '0;
        o_tx_last       = 1'b0;
        o_read_valid    = 1'b0;
        o_read_command  = '0;
        o_read_payload  = '0;
        o_ack_pending   = w_head.ack;
        o_overflow_seen = w_head.ovf;
        if (w_head.is_read) begin
            o_out_kind     = 1'b1;
            o_read_valid   = w_head.rd_valid;
            o_read_command = w_head.bytes[1];
            for (int i = 0; i < cpl_pkg::PAY_BYTES; i++) begin
                o_read_payload[8*i +: 8] = w_head.bytes[2+i];
            end
        end else begin
            o_tx_byte = w_head.bytes[r_byte];
            o_tx_last = w_last_byte;
        end
    end

    // Record pointers and byte position within the head packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
            r_byte <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == IDX_W'(cpl_pkg::TXQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == IDX_W'(cpl_pkg::TXQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (w_out_acc && !w_head.is_read) begin
                r_byte <= w_last_byte ? '0 : r_byte + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // no record is written into a full buffer
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("result buffer written while full");

    // mid-packet position only with a packet at the head
    a_byte_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte != '0) |-> (o_valid && !w_head.is_read))
        else $error("byte position set without a packet at the head");

endmodule

// ===== src/crc8_packet_link_with_ack_retransmit_top.sv =====
// CRC-8 packet link with ack and retransmit. A request is accepted every cycle
// while o_stall is low: a received link byte, a command to send, or a read of
// the received-command queue. Each request is handled in the cycle it is
// accepted and leaves zero results, one read response, or one 7-byte packet;
// results wait in a 4-record buffer, and a packet leaves it one byte per cycle
// of output while i_stall is low; the sustained rate is one request per cycle
// when nothing is sent, lower when every request sends one. o_stall rises
// only while that buffer holds 4 records. Configuration writes are always
// ready and take effect on the next request. No clearing pass after reset.
module crc8_packet_link_with_ack_retransmit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_send_command,
    input  logic [31:0] i_send_payload,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_out_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic        o_read_valid,
    output logic [7:0]  o_read_command,
    output logic [31:0] o_read_payload,
    output logic        o_ack_pending,
    output logic        o_overflow_seen,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]        r_cmd_type, r_ack_type, r_retx_type;
    logic              r_awaiting, n_awaiting;
    logic              r_ovf, n_ovf;
    cpl_pkg::t_pkt     r_last, n_last;

    logic              w_in_acc;
    cpl_pkg::t_rx_done w_rx;
    logic              w_q_push, w_q_pop, w_q_full, w_q_empty;
    cpl_pkg::t_entry   w_q_entry, w_q_head;
    logic              w_push, w_new_tx, w_rec_read;
    cpl_pkg::t_hdr     w_tx_hdr;
    cpl_pkg::t_pkt     w_tx_pkt;
    cpl_pkg::t_rec     w_rec;
    logic              w_txq_full;

    assign w_in_acc    = i_valid && !o_stall;
    assign o_stall     = w_txq_full;
    assign o_cfg_ready = 1'b1;

    // Receive-side packet assembly
    cpl_rx u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (w_in_acc && (i_kind == cpl_pkg::KIND_RX)),
        .i_byte       (i_rx_byte),
        .o_done       (w_rx)
    );

    // Received commands waiting for reads
    cpl_cmdq u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_q_push),
        .i_push_entry (w_q_entry),
        .i_pop        (w_q_pop),
        .o_full       (w_q_full),
        .o_empty      (w_q_empty),
        .o_head       (w_q_head)
    );

    // Queue entry from the received header
    always_comb begin
        for (int j = 0; j <= cpl_pkg::DATA_BYTES; j++) begin
            w_q_entry[j] = w_rx.hdr[1+j];
        end
    end

    // Request handling
    always_comb begin
        n_awaiting = r_awaiting;
        n_ovf      = r_ovf;
        w_push     = 1'b0;
        w_new_tx   = 1'b0;
        w_rec_read = 1'b0;
        w_q_push   = 1'b0;
        w_q_pop    = 1'b0;
        w_tx_hdr   = cpl_pkg::ctrl_hdr(r_retx_type);
        if (w_in_acc) begin
            unique case (i_kind)
                cpl_pkg::KIND_RX: begin
                    if (w_rx.done) begin
                        if (!w_rx.crc_ok) begin
                            // bad CRC: ask for a retransmit
                            w_new_tx = 1'b1;
                        end else if ((w_rx.hdr[0] == r_retx_type)
                                     && (w_rx.hdr[1] == cpl_pkg::FILL_BYTE)) begin
                            // peer asks again: resend last packet
                            w_push = 1'b1;
                        end else if (r_awaiting) begin
                            if ((w_rx.hdr[0] == r_ack_type)
                                && (w_rx.hdr[1] == cpl_pkg::FILL_BYTE)) begin
                                n_awaiting = 1'b0;
                            end
                        end else if (w_rx.hdr[0] == r_cmd_type) begin
                            if (w_q_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                w_q_push = 1'b1;
                            end
                            w_tx_hdr = cpl_pkg::ctrl_hdr(r_ack_type);
                            w_new_tx = 1'b1;
                        end
                    end
                end
                cpl_pkg::KIND_SEND: begin
                    w_tx_hdr[0] = r_cmd_type;
                    w_tx_hdr[1] = i_send_command;
                    for (int i = 0; i < cpl_pkg::DATA_BYTES; i++) begin
                        w_tx_hdr[2+i] = cpl_pkg::FILL_BYTE;
                    end
                    for (int i = 0; i < cpl_pkg::PAY_BYTES; i++) begin
                        w_tx_hdr[2+i] = i_send_payload[8*i +: 8];
                    end
                    w_new_tx   = 1'b1;
                    n_awaiting = 1'b1;
                end
                cpl_pkg::KIND_READ: begin
                    w_rec_read = 1'b1;
                    w_push     = 1'b1;
                    w_q_pop    = !w_q_empty;
                end
                default: begin
                end
            endcase
        end
        if (w_new_tx) begin
            w_push = 1'b1;
        end
    end

    assign w_tx_pkt = cpl_pkg::make_pkt(w_tx_hdr);
    assign n_last   = w_new_tx ? w_tx_pkt : r_last;

    // Result record
    always_comb begin
        w_rec.is_read  = w_rec_read;
        w_rec.rd_valid = !w_q_empty;
        w_rec.ack      = n_awaiting;
        w_rec.ovf      = n_ovf;
        w_rec.bytes    = n_last;
        if (w_rec_read) begin
            w_rec.bytes = '0;
            if (!w_q_empty) begin
                for (int j = 0; j <= cpl_pkg::DATA_BYTES; j++) begin
                    w_rec.bytes[1+j] = w_q_head[j];
                end
            end
        end
    end

    // Result buffer and byte serializer
    cpl_txq u_txq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_push),
        .i_rec           (w_rec),
        .o_full          (w_txq_full),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_kind      (o_out_kind),
        .o_tx_byte       (o_tx_byte),
        .o_tx_last       (o_tx_last),
        .o_read_valid    (o_read_valid),
        .o_read_command  (o_read_command),
        .o_read_payload  (o_read_payload),
        .o_ack_pending   (o_ack_pending),
        .o_overflow_seen (o_overflow_seen)
    );

    // Link state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_ovf      <= 1'b0;
            r_last     <= '0;
        end else begin
            r_awaiting <= n_awaiting;
            r_ovf      <= n_ovf;
            r_last     <= n_last;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_type  <= cpl_pkg::CMD_TYPE_RST;
            r_ack_type  <= cpl_pkg::ACK_TYPE_RST;
            r_retx_type <= cpl_pkg::RETX_TYPE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cpl_pkg::CFG_CMD_TYPE:  r_cmd_type  <= i_cfg_data;
                cpl_pkg::CFG_ACK_TYPE:  r_ack_type  <= i_cfg_data;
                cpl_pkg::CFG_RETX_TYPE: r_retx_type <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a send always leaves the link waiting for an ack
    a_send_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_kind == cpl_pkg::KIND_SEND)) |=> r_awaiting)
        else $error("send did not set the ack wait");

    // overflow only rises when a command met a full queue
    a_ovf_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> $past(w_q_full))
        else $error("overflow flag set without a full queue");

    // every queued command is acknowledged
    a_queued_acked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> (w_push && w_new_tx))
        else $error("command queued without an ack");

endmodule
